FILE: rtl/rws_pkg.sv
package rws_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int FIT_W           = 32;
    localparam int TOTAL_W         = 40;
    localparam int FRAC_W          = 16;
    localparam int IDX_OUT_W       = 8;
    localparam int TARGET_W        = FRAC_W + TOTAL_W;

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_SELECT   = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED   = 2'd0,
        ST_SELECTED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } rws_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } rws_state_t;

    typedef struct packed {
        logic load;
        logic emit_empty;
        logic start_sel;
        logic step;
        logic found;
        logic emit_sel;
    } rws_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic last;
        logic hit;
    } rws_stat_t;

endpackage

FILE: rtl/roulette_wheel_selector.sv
// channel  direction  payload
// s_       in         kind, start_load, fitness_value, random_fraction
// m_       out        chosen_index, total_fitness, status
//
// a load or an empty-table select is written straight into the output register
// a select walk reads one stored entry per cycle from the fitness table ram port;
// the result waits in S_DONE until the output register is free, then enters it
// aresetn is synchronous; the table needs no clearing pass
// s_ready drops during a select (walk and done) and while the output register is held

module roulette_wheel_selector
    import rws_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic                     s_start_load,
    input  logic signed [FIT_W-1:0]  s_fitness_value,
    input  logic [FRAC_W-1:0]        s_random_fraction,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_OUT_W-1:0]     m_chosen_index,
    output logic [TOTAL_W-1:0]       m_total_fitness,
    output logic [1:0]               m_status
);

    rws_cmd_t  cmd;
    rws_stat_t stat;

    rws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .stat    (stat),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    rws_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_start_load      (s_start_load),
        .s_fitness_value   (s_fitness_value),
        .s_random_fraction (s_random_fraction),
        .m_ready           (m_ready),
        .cmd               (cmd),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_chosen_index    (m_chosen_index),
        .m_total_fitness   (m_total_fitness),
        .m_status          (m_status)
    );

endmodule

FILE: rtl/rws_ram.sv
module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/rws_ctrl.sv
module rws_ctrl
    import rws_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_kind,
    input  rws_stat_t stat,
    output logic      s_ready,
    output rws_cmd_t  cmd
);

    rws_state_t state_reg;
    rws_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    if (s_kind == KIND_LOAD) begin
                        cmd.load = 1'b1;
                    end else if (stat.empty) begin
                        cmd.emit_empty = 1'b1;
                    end else begin
                        cmd.start_sel = 1'b1;
                        state_next    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (stat.last || stat.hit) begin
                    cmd.found  = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit_sel = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rws_dp.sv
module rws_dp
    import rws_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_start_load,
    input  logic signed [FIT_W-1:0]  s_fitness_value,
    input  logic [FRAC_W-1:0]        s_random_fraction,
    input  logic                     m_ready,
    input  rws_cmd_t                 cmd,
    output rws_stat_t                stat,
    output logic                     m_valid,
    output logic [IDX_OUT_W-1:0]     m_chosen_index,
    output logic [TOTAL_W-1:0]       m_total_fitness,
    output logic [1:0]               m_status
);

    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int PW    = FIT_W + IW;
    localparam int CMP_W = (PW + 17 > TARGET_W) ? PW + 17 : TARGET_W;

    logic [CW-1:0]       count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    logic [FIT_W-1:0]    best_val_reg, best_val_next;
    logic [TARGET_W-1:0] target_reg;
    logic [PW-1:0]       prefix_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic [IW-1:0]       res_idx_reg;

    logic                 m_valid_reg;
    logic [IDX_OUT_W-1:0] m_idx_reg;
    logic [TOTAL_W-1:0]   m_total_reg;
    rws_status_t          m_status_reg;

    logic [FIT_W-1:0]     fit_v;
    logic [CW-1:0]        eff_count;
    logic [TOTAL_W-1:0]   eff_total;
    logic [IW-1:0]        eff_best_idx;
    logic [FIT_W-1:0]     eff_best_val;
    logic                 full;
    logic [TOTAL_W:0]     sum;
    logic                 ram_we;
    logic [IW-1:0]        ram_raddr;
    logic [FIT_W-1:0]     ram_rdata;
    logic [PW:0]          prefix_hi;
    logic [CMP_W-1:0]     cmp_lo, cmp_hi, cmp_t;

    // clamp negative fitness, apply optional clear
    assign fit_v        = s_fitness_value[FIT_W-1] ? '0 : s_fitness_value;
    assign eff_count    = s_start_load ? '0 : count_reg;
    assign eff_total    = s_start_load ? '0 : total_reg;
    assign eff_best_idx = s_start_load ? '0 : best_idx_reg;
    assign eff_best_val = s_start_load ? '0 : best_val_reg;
    assign full         = (eff_count == CW'(MAX_ENTRIES));
    assign sum          = (TOTAL_W+1)'(eff_total) + (TOTAL_W+1)'(fit_v);
    assign ram_we       = cmd.load && !full;
    assign ram_raddr    = cmd.step ? cmp_idx_reg + IW'(1) : '0;

    always_comb begin
        count_next    = eff_count;
        total_next    = eff_total;
        best_idx_next = eff_best_idx;
        best_val_next = eff_best_val;
        if (!full) begin
            count_next = eff_count + CW'(1);
            total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            if (eff_count == '0 || fit_v > eff_best_val) begin
                best_idx_next = eff_count[IW-1:0];
                best_val_next = fit_v;
            end
        end
    end

    rws_ram #(
        .WIDTH (FIT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (eff_count[IW-1:0]),
        .wdata (fit_v),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // interval test scaled by 2^16 on both sides
    assign prefix_hi = (PW+1)'(prefix_reg) + (PW+1)'(ram_rdata);
    assign cmp_lo    = CMP_W'({prefix_reg, 16'h0000});
    assign cmp_hi    = CMP_W'({prefix_hi, 16'h0000});
    assign cmp_t     = CMP_W'(target_reg);

    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.empty    = (count_reg == '0);
    assign stat.last     = (CW'(cmp_idx_reg) + CW'(1) == count_reg);
    assign stat.hit      = (cmp_lo < cmp_t) && (cmp_t < cmp_hi);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            total_reg    <= '0;
            best_idx_reg <= '0;
            best_val_reg <= '0;
        end else if (cmd.load) begin
            count_reg    <= count_next;
            total_reg    <= total_next;
            best_idx_reg <= best_idx_next;
            best_val_reg <= best_val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_sel) begin
            target_reg  <= TARGET_W'(s_random_fraction) * TARGET_W'(total_reg);
            prefix_reg  <= '0;
            cmp_idx_reg <= '0;
        end else if (cmd.step) begin
            prefix_reg  <= prefix_hi[PW-1:0];
            cmp_idx_reg <= cmp_idx_reg + IW'(1);
        end
        if (cmd.found) begin
            res_idx_reg <= cmp_idx_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load || cmd.emit_empty || cmd.emit_sel) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_idx_reg    <= IDX_OUT_W'(best_idx_next);
            m_total_reg  <= total_next;
            m_status_reg <= full ? ST_FULL : ST_LOADED;
        end else if (cmd.emit_empty) begin
            m_idx_reg    <= '0;
            m_total_reg  <= total_reg;
            m_status_reg <= ST_EMPTY;
        end else if (cmd.emit_sel) begin
            m_idx_reg    <= IDX_OUT_W'(res_idx_reg);
            m_total_reg  <= total_reg;
            m_status_reg <= ST_SELECTED;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_chosen_index  = m_idx_reg;
    assign m_total_fitness = m_total_reg;
    assign m_status        = m_status_reg;

endmodule
